// ----- rtl/multichannel_biquad_iir_filter_macros.svh -----
// Assertion macros shared by the filter modules.
// MBQ_ASSERT is checked only outside reset; MBQ_ASSERT_RST is checked at every edge.
`ifndef MULTICHANNEL_BIQUAD_IIR_FILTER_MACROS_SVH
`define MULTICHANNEL_BIQUAD_IIR_FILTER_MACROS_SVH

`ifndef SYNTHESIS

`define MBQ_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define MBQ_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MBQ_ASSERT(lbl, prop, msg)

`define MBQ_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ----- rtl/mbq_pkg.sv -----
package mbq_pkg;

    localparam int unsigned CHANNELS_DEF = 8;
    localparam int unsigned CHAN_W       = 3;
    localparam int unsigned SAMPLE_W     = 32;
    localparam int unsigned COEF_W       = 32;
    localparam int unsigned PROD_W       = 64;
    localparam int unsigned ACC_W        = 68;
    localparam int unsigned FRAC_SHIFT   = 30;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned PC_W         = 4;

    localparam logic signed [COEF_W-1:0] B0_RST = 32'sd3888751;
    localparam logic signed [COEF_W-1:0] B1_RST = 32'sd7777502;
    localparam logic signed [COEF_W-1:0] B2_RST = 32'sd3888751;
    localparam logic signed [COEF_W-1:0] A1_RST = -32'sd1957103779;
    localparam logic signed [COEF_W-1:0] A2_RST = 32'sd898916953;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 32'sh8000_0000;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          channel;
        logic signed [SAMPLE_W-1:0] sample;
    } in_item_t;

    typedef struct packed {
        logic [CHAN_W-1:0]          out_channel;
        logic signed [SAMPLE_W-1:0] filtered;
        logic                       saturated;
    } out_item_t;

    typedef enum logic [2:0] {COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2} coef_sel_t;
    typedef enum logic [2:0] {OPND_V, OPND_X1, OPND_X2, OPND_Y1, OPND_Y2} opnd_sel_t;
    typedef enum logic [1:0] {ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB} acc_op_t;
    typedef enum logic [1:0] {RND_NONE, RND_Y2, RND_Y1, RND_OUT} rnd_dst_t;
    typedef enum logic [1:0] {BR_NEXT, BR_BAD, BR_PRIMED, BR_END} branch_t;
    typedef enum logic {SEQ_IDLE, SEQ_RUN} seq_state_t;

    typedef struct packed {
        logic            mul_en;
        coef_sel_t       coef_sel;
        opnd_sel_t       opnd_sel;
        acc_op_t         acc_op;
        rnd_dst_t        rnd_dst;
        logic            prime_x;
        branch_t         branch;
        logic [PC_W-1:0] target;
    } ctrl_word_t;

    typedef struct packed {
        ctrl_word_t word;
        logic       active;
    } seq_ctrl_t;

    typedef struct packed {
        logic bad;
        logic primed;
        logic slot_free;
    } dp_status_t;

    // Microprogram addresses.
    localparam logic [PC_W-1:0] PC_START     = 4'd0;
    localparam logic [PC_W-1:0] PC_CHECK     = 4'd1;
    localparam logic [PC_W-1:0] PC_PRIME_B0  = 4'd2;
    localparam logic [PC_W-1:0] PC_PRIME_B1  = 4'd3;
    localparam logic [PC_W-1:0] PC_ROUND_P0  = 4'd4;
    localparam logic [PC_W-1:0] PC_PRIME_A2  = 4'd5;
    localparam logic [PC_W-1:0] PC_PRIME_SUB = 4'd6;
    localparam logic [PC_W-1:0] PC_ROUND_P1  = 4'd7;
    localparam logic [PC_W-1:0] PC_MUL_B0    = 4'd8;
    localparam logic [PC_W-1:0] PC_MUL_B1    = 4'd9;
    localparam logic [PC_W-1:0] PC_MUL_B2    = 4'd10;
    localparam logic [PC_W-1:0] PC_MUL_A1    = 4'd11;
    localparam logic [PC_W-1:0] PC_MUL_A2    = 4'd12;
    localparam logic [PC_W-1:0] PC_SUB_A2    = 4'd13;
    localparam logic [PC_W-1:0] PC_ROUND_Y   = 4'd14;
    localparam logic [PC_W-1:0] PC_BAD       = 4'd15;

    localparam ctrl_word_t UC_NOP = '{
        mul_en:   1'b0,
        coef_sel: COEF_B0,
        opnd_sel: OPND_V,
        acc_op:   ACC_HOLD,
        rnd_dst:  RND_NONE,
        prime_x:  1'b0,
        branch:   BR_NEXT,
        target:   PC_START
    };

    // The product issued in one step is accumulated in the following step.
    function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
        ctrl_word_t w;
        w = UC_NOP;
        case (pc)
            PC_START:
            begin
                w.branch = BR_BAD;
                w.target = PC_BAD;
            end
            PC_CHECK:
            begin
                w.branch = BR_PRIMED;
                w.target = PC_MUL_B0;
            end
            PC_PRIME_B0:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B0;
                w.opnd_sel = OPND_V;
            end
            PC_PRIME_B1:
            begin
                w.acc_op   = ACC_LOAD;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B1;
                w.opnd_sel = OPND_V;
            end
            PC_ROUND_P0:
            begin
                w.rnd_dst = RND_Y2;
                w.acc_op  = ACC_ADD;
                w.prime_x = 1'b1;
            end
            PC_PRIME_A2:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A2;
                w.opnd_sel = OPND_Y2;
            end
            PC_PRIME_SUB:
            begin
                w.acc_op = ACC_SUB;
            end
            PC_ROUND_P1:
            begin
                w.rnd_dst = RND_Y1;
            end
            PC_MUL_B0:
            begin
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B0;
                w.opnd_sel = OPND_V;
            end
            PC_MUL_B1:
            begin
                w.acc_op   = ACC_LOAD;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B1;
                w.opnd_sel = OPND_X1;
            end
            PC_MUL_B2:
            begin
                w.acc_op   = ACC_ADD;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_B2;
                w.opnd_sel = OPND_X2;
            end
            PC_MUL_A1:
            begin
                w.acc_op   = ACC_ADD;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A1;
                w.opnd_sel = OPND_Y1;
            end
            PC_MUL_A2:
            begin
                w.acc_op   = ACC_SUB;
                w.mul_en   = 1'b1;
                w.coef_sel = COEF_A2;
                w.opnd_sel = OPND_Y2;
            end
            PC_SUB_A2:
            begin
                w.acc_op = ACC_SUB;
            end
            PC_ROUND_Y:
            begin
                w.rnd_dst = RND_OUT;
                w.branch  = BR_END;
            end
            PC_BAD:
            begin
                w.rnd_dst = RND_OUT;
                w.branch  = BR_END;
            end
            default:
            begin
                w = UC_NOP;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/mbq_sequencer.sv -----
`include "multichannel_biquad_iir_filter_macros.svh"

module mbq_sequencer (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  mbq_pkg::dp_status_t    status,
    output mbq_pkg::seq_ctrl_t     ctrl,
    output logic                   ready
);

    mbq_pkg::seq_state_t              state_reg;
    mbq_pkg::seq_state_t              state_next;
    logic [mbq_pkg::PC_W-1:0]         pc_reg;
    logic [mbq_pkg::PC_W-1:0]         pc_next;
    mbq_pkg::ctrl_word_t              word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mbq_pkg::SEQ_IDLE;
            pc_reg    <= mbq_pkg::PC_START;
        end
        else
        begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
        end
    end

    always_comb
    begin
        word        = mbq_pkg::ucode(pc_reg);
        state_next  = state_reg;
        pc_next     = pc_reg;
        ctrl.word   = word;
        ctrl.active = 1'b0;
        ready       = 1'b0;
        case (state_reg)
            mbq_pkg::SEQ_IDLE:
            begin
                ready = 1'b1;
                if (start)
                begin
                    state_next = mbq_pkg::SEQ_RUN;
                    pc_next    = mbq_pkg::PC_START;
                end
            end
            mbq_pkg::SEQ_RUN:
            begin
                ctrl.active = 1'b1;
                case (word.branch)
                    mbq_pkg::BR_NEXT:
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                    mbq_pkg::BR_BAD:
                    begin
                        pc_next = status.bad ? word.target : pc_reg + 1'b1;
                    end
                    mbq_pkg::BR_PRIMED:
                    begin
                        pc_next = status.primed ? word.target : pc_reg + 1'b1;
                    end
                    mbq_pkg::BR_END:
                    begin
                        // The last step waits here while the output register is still full.
                        ctrl.active = status.slot_free;
                        if (status.slot_free)
                        begin
                            state_next = mbq_pkg::SEQ_IDLE;
                        end
                    end
                    default:
                    begin
                        pc_next = pc_reg + 1'b1;
                    end
                endcase
            end
            default:
            begin
                state_next = mbq_pkg::SEQ_IDLE;
            end
        endcase
    end

    `MBQ_ASSERT(a_start_pc, start |=> (state_reg == mbq_pkg::SEQ_RUN && pc_reg == mbq_pkg::PC_START), "sequencer did not start at the first step")
    `MBQ_ASSERT(a_end_hold, (state_reg == mbq_pkg::SEQ_RUN && word.branch == mbq_pkg::BR_END && !status.slot_free) |=> (state_reg == mbq_pkg::SEQ_RUN && $stable(pc_reg)), "final step left while output was full")
    `MBQ_ASSERT(a_run_stays, (state_reg == mbq_pkg::SEQ_RUN && word.branch != mbq_pkg::BR_END) |=> state_reg == mbq_pkg::SEQ_RUN, "program ended before its final step")
    `MBQ_ASSERT_RST(a_rst_idle, !rst_n |=> state_reg == mbq_pkg::SEQ_IDLE, "sequencer not idle after reset")

endmodule

// ----- rtl/mbq_datapath.sv -----
`include "multichannel_biquad_iir_filter_macros.svh"

module mbq_datapath #(
    parameter int unsigned CHANNELS = mbq_pkg::CHANNELS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  mbq_pkg::in_item_t                   in_data,
    input  mbq_pkg::seq_ctrl_t                  ctrl,
    output mbq_pkg::dp_status_t                 status,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mbq_pkg::out_item_t                  out_data,
    input  logic                                cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mbq_pkg::COEF_W-1:0]          cfg_data
);

    localparam int unsigned IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int unsigned CMP_W =
        ((IDX_W > mbq_pkg::CHAN_W) ? IDX_W : mbq_pkg::CHAN_W) + 1;
    localparam int unsigned TOP_BIT = mbq_pkg::FRAC_SHIFT + mbq_pkg::SAMPLE_W - 1;
    localparam logic signed [mbq_pkg::ACC_W-1:0] HALF_LSB =
        mbq_pkg::ACC_W'(1) << (mbq_pkg::FRAC_SHIFT - 1);

    logic signed [mbq_pkg::COEF_W-1:0]    b0_reg, b1_reg, b2_reg, a1_reg, a2_reg;
    logic [CHANNELS-1:0]                  primed_bits_reg;

    logic signed [mbq_pkg::SAMPLE_W-1:0]  x1_mem [CHANNELS];
    logic signed [mbq_pkg::SAMPLE_W-1:0]  x2_mem [CHANNELS];
    logic signed [mbq_pkg::SAMPLE_W-1:0]  y1_mem [CHANNELS];
    logic signed [mbq_pkg::SAMPLE_W-1:0]  y2_mem [CHANNELS];

    logic signed [mbq_pkg::SAMPLE_W-1:0]  v_reg, x1_reg, x2_reg, y1_reg, y2_reg;
    logic [mbq_pkg::CHAN_W-1:0]           ch_reg;
    logic [IDX_W-1:0]                     idx_reg;
    logic                                 bad_reg;
    logic                                 primed_reg;
    logic signed [mbq_pkg::PROD_W-1:0]    prod_reg;
    logic signed [mbq_pkg::ACC_W-1:0]     acc_reg;
    logic                                 out_valid_reg;
    mbq_pkg::out_item_t                   out_data_reg;

    logic [CMP_W-1:0]                     ch_ext;
    logic                                 in_range;
    logic [IDX_W-1:0]                     in_idx;
    logic signed [mbq_pkg::COEF_W-1:0]    mul_a;
    logic signed [mbq_pkg::SAMPLE_W-1:0]  mul_b;
    logic signed [mbq_pkg::PROD_W-1:0]    prod;
    logic signed [mbq_pkg::ACC_W-1:0]     prod_ext;
    logic signed [mbq_pkg::ACC_W-1:0]     rnd_sum;
    logic                                 rnd_fits;
    logic signed [mbq_pkg::SAMPLE_W-1:0]  rnd_val;
    logic                                 rnd_sat;
    logic                                 do_end;

    always_comb
    begin
        ch_ext   = CMP_W'(in_data.channel);
        in_range = ch_ext < CMP_W'(CHANNELS);
        in_idx   = in_range ? ch_ext[IDX_W-1:0] : '0;
    end

    always_comb
    begin
        case (ctrl.word.coef_sel)
            mbq_pkg::COEF_B0: mul_a = b0_reg;
            mbq_pkg::COEF_B1: mul_a = b1_reg;
            mbq_pkg::COEF_B2: mul_a = b2_reg;
            mbq_pkg::COEF_A1: mul_a = a1_reg;
            mbq_pkg::COEF_A2: mul_a = a2_reg;
            default:          mul_a = b0_reg;
        endcase
        case (ctrl.word.opnd_sel)
            mbq_pkg::OPND_V:  mul_b = v_reg;
            mbq_pkg::OPND_X1: mul_b = x1_reg;
            mbq_pkg::OPND_X2: mul_b = x2_reg;
            mbq_pkg::OPND_Y1: mul_b = y1_reg;
            mbq_pkg::OPND_Y2: mul_b = y2_reg;
            default:          mul_b = v_reg;
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign prod_ext = mbq_pkg::ACC_W'(prod_reg);

    // Round half up, then clamp anything outside the signed 32-bit range.
    always_comb
    begin
        rnd_sum  = acc_reg + HALF_LSB;
        rnd_fits = (rnd_sum[mbq_pkg::ACC_W-1:TOP_BIT] == '0) ||
                   (rnd_sum[mbq_pkg::ACC_W-1:TOP_BIT] == '1);
        rnd_sat  = !rnd_fits;
        if (rnd_fits)
        begin
            rnd_val = rnd_sum[TOP_BIT:mbq_pkg::FRAC_SHIFT];
        end
        else
        begin
            rnd_val = rnd_sum[mbq_pkg::ACC_W-1] ? mbq_pkg::SAMPLE_MIN : mbq_pkg::SAMPLE_MAX;
        end
    end

    assign do_end = ctrl.active && (ctrl.word.branch == mbq_pkg::BR_END);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg          <= mbq_pkg::B0_RST;
            b1_reg          <= mbq_pkg::B1_RST;
            b2_reg          <= mbq_pkg::B2_RST;
            a1_reg          <= mbq_pkg::A1_RST;
            a2_reg          <= mbq_pkg::A2_RST;
            primed_bits_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (mbq_pkg::cfg_reg_t'(cfg_index))
                    mbq_pkg::REG_B0: b0_reg <= cfg_data;
                    mbq_pkg::REG_B1: b1_reg <= cfg_data;
                    mbq_pkg::REG_B2: b2_reg <= cfg_data;
                    mbq_pkg::REG_A1: a1_reg <= cfg_data;
                    mbq_pkg::REG_A2: a2_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (do_end && !bad_reg)
            begin
                primed_bits_reg[idx_reg] <= 1'b1;
            end
            if (do_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // History memories: read at an accepted channel, written at the end if in range.
    always_ff @(posedge clk)
    begin
        if (do_end && !bad_reg)
        begin
            x1_mem[idx_reg] <= v_reg;
            x2_mem[idx_reg] <= x1_reg;
            y1_mem[idx_reg] <= rnd_val;
            y2_mem[idx_reg] <= y1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg      <= in_data.sample;
            ch_reg     <= in_data.channel;
            idx_reg    <= in_idx;
            bad_reg    <= !in_range;
            primed_reg <= primed_bits_reg[in_idx];
            x1_reg     <= x1_mem[in_idx];
            x2_reg     <= x2_mem[in_idx];
            y1_reg     <= y1_mem[in_idx];
            y2_reg     <= y2_mem[in_idx];
        end
        if (ctrl.active)
        begin
            if (ctrl.word.mul_en)
            begin
                prod_reg <= prod;
            end
            case (ctrl.word.acc_op)
                mbq_pkg::ACC_LOAD: acc_reg <= prod_ext;
                mbq_pkg::ACC_ADD:  acc_reg <= acc_reg + prod_ext;
                mbq_pkg::ACC_SUB:  acc_reg <= acc_reg - prod_ext;
                default: ;
            endcase
            if (ctrl.word.prime_x)
            begin
                x1_reg <= v_reg;
                x2_reg <= v_reg;
            end
            case (ctrl.word.rnd_dst)
                mbq_pkg::RND_Y2: y2_reg <= rnd_val;
                mbq_pkg::RND_Y1: y1_reg <= rnd_val;
                mbq_pkg::RND_OUT:
                begin
                    out_data_reg.out_channel <= ch_reg;
                    out_data_reg.filtered    <= bad_reg ? '0 : rnd_val;
                    out_data_reg.saturated   <= bad_reg ? 1'b0 : rnd_sat;
                end
                default: ;
            endcase
        end
    end

    always_comb
    begin
        status.bad       = bad_reg;
        status.primed    = primed_reg;
        status.slot_free = !out_valid_reg || out_ready;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    `MBQ_ASSERT(a_sat_limit, (out_valid_reg && out_data_reg.saturated) |-> (out_data_reg.filtered == mbq_pkg::SAMPLE_MAX || out_data_reg.filtered == mbq_pkg::SAMPLE_MIN), "saturated flag without a clipped value")
    `MBQ_ASSERT(a_out_from_end, $rose(out_valid_reg) |-> $past(do_end), "result shown without a final step")
    `MBQ_ASSERT(a_bad_zero, (do_end && bad_reg) |=> (out_data_reg.filtered == '0 && !out_data_reg.saturated), "unknown channel gave a nonzero result")

endmodule

// ----- rtl/multichannel_biquad_iir_filter.sv -----
// Multichannel direct form I biquad, Q16.16 samples, Q2.30 coefficients.
// Input channel: in_valid/in_ready carry a channel index and a sample. Output
// channel: out_valid/out_ready carry the channel, the filtered sample and a
// flag that is set when the result was clipped to the 32-bit range.
// Coefficients are written through cfg_we/cfg_index/cfg_data; the user must
// write them only while the block is idle, as the block does not enforce it.
// A write to an index past the last coefficient is ignored. Each transaction
// runs a microprogram on one shared 32x32 multiplier and a wide accumulator,
// one step per cycle unless the last step waits for a full output register.
// A primed channel runs the start and check steps, the b0, b1, b2, a1 and a2
// multiply steps and a rounding step; the first sample on a channel adds the
// priming steps. A channel index beyond the channel count gives a zero result.
// A new transaction is accepted while a finished result still waits in the
// output register; if the receiver stalls, the next result holds in its last
// step until the output register is free.
// Reset restores the default coefficients and marks every channel unprimed;
// no clearing pass is needed.
module multichannel_biquad_iir_filter #(
    parameter int unsigned CHANNELS = mbq_pkg::CHANNELS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  mbq_pkg::in_item_t               in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output mbq_pkg::out_item_t              out_data,
    input  logic                            cfg_we,
    input  logic [mbq_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mbq_pkg::COEF_W-1:0]      cfg_data
);

    logic                   start;
    mbq_pkg::seq_ctrl_t     ctrl;
    mbq_pkg::dp_status_t    status;

    assign start = in_valid && in_ready;

    mbq_sequencer u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .ctrl   (ctrl),
        .ready  (in_ready)
    );

    mbq_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .in_data   (in_data),
        .ctrl      (ctrl),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

endmodule
